// ===== hw/rtl/rolling_weak_checksum_top_assert.svh =====
// Assertion macros for the rolling weak checksum block.
// Used by rolling_weak_checksum_top; the enclosing module must provide clk and rst_n.
`ifndef ROLLING_WEAK_CHECKSUM_TOP_ASSERT_SVH
`define ROLLING_WEAK_CHECKSUM_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rwc_pkg.sv =====
// Shared types and constants for the rolling weak checksum block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package rwc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned WEAK_W      = 2 * SUM_W;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned START_W     = 40;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = 2;
  localparam int unsigned FIFO_CNT_W  = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  // Register index, taken from paddr bit 2.
  typedef enum logic {
    REG_WINDOW_LEN = 1'b0,
    REG_BLOCK_MODE = 1'b1
  } rwc_reg_t;

  typedef struct packed {
    logic               checksum_valid;
    logic [WEAK_W-1:0]  weak_sum;
    logic [SUM_W-1:0]   bucket_index;
    logic [START_W-1:0] window_start;
  } rwc_result_t;

endpackage

// ===== hw/rtl/rwc_if.sv =====
// Valid/ready channel interfaces for the rolling weak checksum block.
// Depends on rwc_pkg for the field widths.
`timescale 1ns / 1ps

interface rwc_in_if import rwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              stream_end;

  modport source (output valid, output byte_value, output stream_end, input ready);
  modport sink   (input valid, input byte_value, input stream_end, output ready);
endinterface

interface rwc_out_if import rwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               checksum_valid;
  logic [WEAK_W-1:0]  weak_sum;
  logic [SUM_W-1:0]   bucket_index;
  logic [START_W-1:0] window_start;

  modport source (output valid, output checksum_valid, output weak_sum,
                  output bucket_index, output window_start, input ready);
  modport sink   (input valid, input checksum_valid, input weak_sum,
                  input bucket_index, input window_start, output ready);
endinterface

// ===== hw/rtl/rolling_weak_checksum_top.sv =====
// Rolling weak checksum: takes one byte per cycle while the output queue has room and returns
// one result per byte. The result is held in the first stage register and then written into
// the output queue, from which it is offered. The byte taken at transfer is written into the
// window memory in the same cycle in which the outgoing byte is read from it, so the single
// read/write port of that memory sets the rate of one byte per clock.
// Results wait in a four-entry output queue, so input is taken while the consumer stalls
// until the queue is full. No clearing pass is needed after reset: the outgoing byte is used
// only at addresses below the mark one past the highest address written since reset.
// Depends on rwc_pkg, rwc_if.sv and rolling_weak_checksum_top_assert.svh.
`timescale 1ns / 1ps
`include "rolling_weak_checksum_top_assert.svh"

module rolling_weak_checksum_top
  import rwc_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 65536,
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rwc_in_if.sink                in_ch,
  rwc_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned ADDR_W = $clog2(MAX_WINDOW);
  localparam int unsigned HWM_W  = ADDR_W + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WINDOW);

  // Configuration registers
  logic [LEN_W-1:0] cfg_len_r;
  logic             cfg_block_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= LEN_RESET;
      cfg_block_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (rwc_reg_t'(paddr[2]))
        REG_WINDOW_LEN: cfg_len_r   <= pwdata[LEN_W-1:0];
        REG_BLOCK_MODE: cfg_block_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rwc_reg_t'(paddr[2]))
      REG_WINDOW_LEN: prdata = CFG_DATA_W'(cfg_len_r);
      REG_BLOCK_MODE: prdata = CFG_DATA_W'(cfg_block_r);
      default:        prdata = '0;
    endcase
  end

  logic [LEN_W-1:0] len_c;
  always_comb begin
    if (cfg_len_r == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(cfg_len_r) > MAX_WINDOW) begin
      len_c = MAX_LEN;
    end else begin
      len_c = cfg_len_r;
    end
  end

  // Stream state
  logic [ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic [HWM_W-1:0]       hwm_r, hwm_nxt;
  logic [LEN_W-1:0]       fill_r, fill_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;

  // First stage: the byte has been taken and the memory read is in flight.
  logic               a_valid_r;
  logic [BYTE_W-1:0]  a_x_r, a_x_nxt;
  logic               a_leave_r, a_leave_nxt;
  logic [SUM_W-1:0]   a_prod_r, a_prod_nxt;
  logic               a_block_r;
  logic               a_ok_r, a_ok_nxt;
  logic [START_W-1:0] a_start_r, a_start_nxt;
  logic               a_clr_r, a_clr_nxt;

  logic [SUM_W-1:0] s1_r, s2_r;
  logic [BYTE_W-1:0] mem_q_r;
  logic [BYTE_W-1:0] window_mem [MAX_WINDOW];

  logic [FIFO_CNT_W-1:0] fifo_cnt_r;
  logic in_acc;
  logic pop;

  assign in_ch.ready = ({1'b0, fifo_cnt_r} + (FIFO_CNT_W + 1)'(a_valid_r))
                       < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign in_acc = in_ch.valid && in_ch.ready;

  logic [ADDR_W-1:0] p0;
  logic [31:0]       p1;
  logic [LEN_W-1:0]  pos1;
  logic [23:0]       prod_full;

  always_comb begin
    p0          = (32'(ptr_r) >= 32'(len_c)) ? '0 : ptr_r;
    p1          = 32'(p0) + 32'd1;
    pos1        = fill_r + LEN_W'(1);
    ptr_nxt     = ptr_r;
    hwm_nxt     = hwm_r;
    fill_nxt    = fill_r;
    off_nxt     = off_r + OFFSET_BITS'(1);
    a_x_nxt     = in_ch.byte_value;
    a_leave_nxt = 1'b0;
    a_ok_nxt    = 1'b0;
    a_start_nxt = '0;
    a_clr_nxt   = in_ch.stream_end;
    if (!cfg_block_r) begin
      prod_full   = len_c[SUM_W-1:0] * in_ch.byte_value;
      a_leave_nxt = (fill_r >= len_c) && (32'(p0) < 32'(hwm_r));
      ptr_nxt     = (p1 >= 32'(len_c)) ? '0 : ADDR_W'(p1);
      if (p1 > 32'(hwm_r)) begin
        hwm_nxt = HWM_W'(p1);
      end
      fill_nxt = (fill_r >= len_c) ? len_c : pos1;
      a_ok_nxt = fill_nxt >= len_c;
      if (a_ok_nxt) begin
        a_start_nxt = START_W'(off_r - OFFSET_BITS'(len_c - LEN_W'(1)));
      end
    end else begin
      prod_full = pos1[SUM_W-1:0] * in_ch.byte_value;
      fill_nxt  = pos1;
      a_ok_nxt  = in_ch.stream_end || (pos1 >= len_c);
      if (a_ok_nxt) begin
        a_start_nxt = START_W'(off_r - OFFSET_BITS'(fill_r));
        fill_nxt    = '0;
        a_clr_nxt   = 1'b1;
      end
    end
    a_prod_nxt = prod_full[SUM_W-1:0];
    if (in_ch.stream_end) begin
      ptr_nxt  = '0;
      fill_nxt = '0;
      off_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      hwm_r     <= '0;
      fill_r    <= '0;
      off_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_acc;
      if (in_acc) begin
        ptr_r  <= ptr_nxt;
        hwm_r  <= hwm_nxt;
        fill_r <= fill_nxt;
        off_r  <= off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_x_r     <= a_x_nxt;
      a_leave_r <= a_leave_nxt;
      a_prod_r  <= a_prod_nxt;
      a_block_r <= cfg_block_r;
      a_ok_r    <= a_ok_nxt;
      a_start_r <= a_start_nxt;
      a_clr_r   <= a_clr_nxt;
    end
  end

  // The read returns the old byte; the new byte replaces it in the same cycle.
  always_ff @(posedge clk) begin
    if (in_acc && !cfg_block_r) begin
      mem_q_r       <= window_mem[p0];
      window_mem[p0] <= in_ch.byte_value;
    end
  end

  // Second stage: roll the sums and build the result.
  logic [BYTE_W-1:0] leave8;
  logic [SUM_W-1:0]  s1_new, s2_new;
  rwc_result_t       res;

  always_comb begin
    leave8 = a_leave_r ? mem_q_r : '0;
    if (!a_block_r) begin
      s2_new = s2_r + a_prod_r - s1_r;
      s1_new = s1_r + SUM_W'(a_x_r) - SUM_W'(leave8);
    end else begin
      s2_new = s2_r + a_prod_r;
      s1_new = s1_r + SUM_W'(a_x_r);
    end
    res.checksum_valid = a_ok_r;
    res.weak_sum       = {s2_new, s1_new};
    res.bucket_index   = s2_new ^ s1_new;
    res.window_start   = a_start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (a_valid_r) begin
      s1_r <= a_clr_r ? '0 : s1_new;
      s2_r <= a_clr_r ? '0 : s2_new;
    end
  end

  // Output queue. Input is only taken when a slot is reserved for it.
  rwc_result_t        fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (a_valid_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CNT_W'(a_valid_r) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  rwc_result_t head;
  assign head                  = fifo_mem[rd_ptr_r];
  assign out_ch.valid          = fifo_cnt_r != '0;
  assign out_ch.checksum_valid = head.checksum_valid;
  assign out_ch.weak_sum       = head.weak_sum;
  assign out_ch.bucket_index   = head.bucket_index;
  assign out_ch.window_start   = head.window_start;

  logic fifo_full;
  logic end_acc;
  logic ctrs_zero;
  assign fifo_full = fifo_cnt_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign end_acc   = in_acc && in_ch.stream_end;
  assign ctrs_zero = (fill_r == '0) && (ptr_r == '0) && (off_r == '0);

  `RWC_CHECK(a_fifo_bound, 1'b1, fifo_cnt_r <= FIFO_CNT_W'(FIFO_DEPTH), "output queue overfull")
  `RWC_CHECK(a_slot_reserved, a_valid_r, !fifo_full, "no slot for result")
  `RWC_CHECK(a_hwm_bound, 1'b1, 32'(hwm_r) <= MAX_WINDOW, "written mark past window memory")
  `RWC_CHECK_NEXT(a_end_clears, end_acc, ctrs_zero, "stream end did not clear counters")

endmodule
